@@ hdl/ps2_mouse_packet_tracker_assert.svh @@
// ----------------------------------------------------------------------------
// ps2 mouse packet tracker assertion macros
// shared helpers for concurrent checks clocked on clk
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH

// check held off while rst is high
`define PS2MT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds through reset
`define PS2MT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/ps2mt_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2mt_pkg
// types, constants and helpers shared by the ps2 mouse packet tracker
// ----------------------------------------------------------------------------
package ps2mt_pkg;

  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned DELTA_W = 9;
  localparam int unsigned SUM_W   = 14;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1024;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd768;

  // header bits
  localparam int unsigned HDR_LEFT_BIT  = 0;
  localparam int unsigned HDR_SYNC_BIT  = 3;
  localparam int unsigned HDR_XSIGN_BIT = 4;
  localparam int unsigned HDR_YSIGN_BIT = 5;

  // register index taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    EV_MOVE = 2'd0,
    EV_DOWN = 2'd1,
    EV_UP   = 2'd2
  } event_kind_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_XDELTA = 3'b010,
    PH_YDELTA = 3'b100
  } phase_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic                      left;
  } pkt_t;

  function automatic logic [COORD_W-1:0] clamp_max(input logic [SIZE_W-1:0] size);
    logic [COORD_W-1:0] m;
    if (size == '0) begin
      m = '0;
    end else if (size[SIZE_W-1]) begin
      m = '1;
    end else begin
      m = COORD_W'(size - 1'b1);
    end
    return m;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [SUM_W-1:0] v,
                                                     input logic [COORD_W-1:0] maxv);
    logic [COORD_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v[SUM_W-2:0] > {1'b0, maxv}) begin
      r = maxv;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/ps2mt_fifo.sv @@
// ----------------------------------------------------------------------------
// ps2mt_fifo
// small register queue carrying packets from the byte front end to the back end
// ----------------------------------------------------------------------------
module ps2mt_fifo #(
  parameter int Width = 19,
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic [Width-1:0] pop_data,
  output logic             pop_valid
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/ps2mt_front.sv @@
// ----------------------------------------------------------------------------
// ps2mt_front
// takes data words, filters mouse bytes and assembles three-byte packets
// ----------------------------------------------------------------------------
module ps2mt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              from_mouse,
  output logic              push,
  output ps2mt_pkg::pkt_t   push_pkt,
  input  logic              push_ready
);

  ps2mt_pkg::phase_t phase;
  logic [7:0]        header_byte;
  logic [7:0]        x_delta_byte;
  logic              take;

  assign in_ready = push_ready;
  assign take     = in_valid && in_ready && from_mouse;
  assign push     = take && (phase == ps2mt_pkg::PH_YDELTA);

  assign push_pkt.dx   = {header_byte[ps2mt_pkg::HDR_XSIGN_BIT], x_delta_byte};
  assign push_pkt.dy   = {header_byte[ps2mt_pkg::HDR_YSIGN_BIT], data_byte};
  assign push_pkt.left = header_byte[ps2mt_pkg::HDR_LEFT_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ps2mt_pkg::PH_HEADER;
      header_byte  <= '0;
      x_delta_byte <= '0;
    end else if (take) begin
      unique case (phase)
        ps2mt_pkg::PH_XDELTA: begin
          x_delta_byte <= data_byte;
          phase        <= ps2mt_pkg::PH_YDELTA;
        end
        ps2mt_pkg::PH_YDELTA: begin
          phase <= ps2mt_pkg::PH_HEADER;
        end
        default: begin
          header_byte <= data_byte;
          phase       <= data_byte[ps2mt_pkg::HDR_SYNC_BIT] ? ps2mt_pkg::PH_XDELTA
                                                            : ps2mt_pkg::PH_HEADER;
        end
      endcase
    end
  end

endmodule

@@ hdl/ps2mt_back.sv @@
// ----------------------------------------------------------------------------
// ps2mt_back
// applies packet deltas to the clamped cursor and emits move and button words
// ----------------------------------------------------------------------------
module ps2mt_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [ps2mt_pkg::SIZE_W-1:0]       screen_width,
  input  logic [ps2mt_pkg::SIZE_W-1:0]       screen_height,
  input  logic                               pkt_valid,
  input  ps2mt_pkg::pkt_t                    pkt,
  output logic                               pkt_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         event_kind,
  output logic [ps2mt_pkg::COORD_W-1:0]      cursor_x_out,
  output logic [ps2mt_pkg::COORD_W-1:0]      cursor_y_out,
  output logic                               last
);

  logic [ps2mt_pkg::COORD_W-1:0]       cursor_x;
  logic [ps2mt_pkg::COORD_W-1:0]       cursor_y;
  logic                                left_was_down;
  logic                                pend;
  ps2mt_pkg::event_kind_t              pend_kind;
  logic                                out_free;
  logic                                btn;
  logic signed [ps2mt_pkg::SUM_W-1:0]  sum_x;
  logic signed [ps2mt_pkg::SUM_W-1:0]  sum_y;
  logic [ps2mt_pkg::COORD_W-1:0]       cursor_x_next;
  logic [ps2mt_pkg::COORD_W-1:0]       cursor_y_next;

  assign out_free = !out_valid || out_ready;
  assign pkt_pop  = pkt_valid && out_free && !pend;
  assign btn      = (pkt.left != left_was_down);

  assign sum_x = $signed({2'b00, cursor_x}) + ps2mt_pkg::SUM_W'(pkt.dx);
  assign sum_y = $signed({2'b00, cursor_y}) - ps2mt_pkg::SUM_W'(pkt.dy);
  assign cursor_x_next = ps2mt_pkg::clamp_coord(sum_x, ps2mt_pkg::clamp_max(screen_width));
  assign cursor_y_next = ps2mt_pkg::clamp_coord(sum_y, ps2mt_pkg::clamp_max(screen_height));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      pend          <= 1'b0;
      cursor_x      <= '0;
      cursor_y      <= '0;
      left_was_down <= 1'b0;
    end else if (out_free) begin
      if (pend) begin
        out_valid    <= 1'b1;
        event_kind   <= pend_kind;
        cursor_x_out <= cursor_x;
        cursor_y_out <= cursor_y;
        last         <= 1'b1;
        pend         <= 1'b0;
      end else if (pkt_pop) begin
        out_valid    <= 1'b1;
        event_kind   <= ps2mt_pkg::EV_MOVE;
        cursor_x_out <= cursor_x_next;
        cursor_y_out <= cursor_y_next;
        last         <= !btn;
        cursor_x     <= cursor_x_next;
        cursor_y     <= cursor_y_next;
        if (btn) begin
          pend          <= 1'b1;
          pend_kind     <= pkt.left ? ps2mt_pkg::EV_DOWN : ps2mt_pkg::EV_UP;
          left_was_down <= pkt.left;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/ps2_mouse_packet_tracker.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// cursor tracking from a ps2 mouse byte stream
// ----------------------------------------------------------------------------
// input channel: one word per byte read from the controller, data_byte plus
// from_mouse; words with from_mouse low are taken and dropped. mouse bytes
// form header, x delta and y delta packets, resyncing on header bit 3.
// output channel: per packet a move word with the clamped cursor, followed
// by a left button down or up word when the button changed; last marks the
// final word of a packet.
// a word is taken every cycle while the packet queue has room. the move word
// of a packet is registered in the packet queue and then in the output
// register; a button change adds a second word from the pending state. the
// back end holds one output register and is fed by a queue of Depth packets,
// so a stalled receiver stops the input only once that queue is full.
// apb registers: screen_width at 0x0, screen_height at 0x4, written while
// idle. reset clears cursor, button state and packet phase, empties the
// queue, and loads 1024 x 768.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker #(
  parameter int Depth = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        from_mouse,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [11:0] cursor_x_out,
  output logic [11:0] cursor_y_out,
  output logic        last
);

  localparam int PktW = $bits(ps2mt_pkg::pkt_t);

  logic [ps2mt_pkg::SIZE_W-1:0] screen_width;
  logic [ps2mt_pkg::SIZE_W-1:0] screen_height;
  logic                         push;
  logic                         push_ready;
  ps2mt_pkg::pkt_t              push_pkt;
  logic                         pop;
  logic                         pop_valid;
  logic [PktW-1:0]              pop_data;
  logic                         wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= ps2mt_pkg::WIDTH_RESET;
      screen_height <= ps2mt_pkg::HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        ps2mt_pkg::REG_WIDTH:  screen_width  <= pwdata[ps2mt_pkg::SIZE_W-1:0];
        ps2mt_pkg::REG_HEIGHT: screen_height <= pwdata[ps2mt_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ps2mt_pkg::REG_WIDTH:  prdata = 32'(screen_width);
      ps2mt_pkg::REG_HEIGHT: prdata = 32'(screen_height);
      default:               prdata = '0;
    endcase
  end

  ps2mt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .from_mouse (from_mouse),
    .push       (push),
    .push_pkt   (push_pkt),
    .push_ready (push_ready)
  );

  ps2mt_fifo #(
    .Width (PktW),
    .Depth (Depth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_pkt),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid)
  );

  ps2mt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .pkt_valid     (pop_valid),
    .pkt           (ps2mt_pkg::pkt_t'(pop_data)),
    .pkt_pop       (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .cursor_x_out  (cursor_x_out),
    .cursor_y_out  (cursor_y_out),
    .last          (last)
  );

endmodule

@@ hdl/ps2mt_checker.sv @@
// ----------------------------------------------------------------------------
// ps2mt_checker
// port level checks on the result channel of the packet tracker
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_tracker_assert.svh"

module ps2mt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_kind,
  input logic [11:0] cursor_x_out,
  input logic [11:0] cursor_y_out,
  input logic        last
);

  `PS2MT_ASSERT_ALWAYS(a_rst_clears_out, rst |=> !out_valid, "out_valid after reset")

  `PS2MT_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(cursor_x_out) && $stable(cursor_y_out) && $stable(last), "stalled word changed")

  `PS2MT_ASSERT(a_button_is_last, out_valid && event_kind != ps2mt_pkg::EV_MOVE |-> last, "button word not last")

  `PS2MT_ASSERT(a_button_follows, out_valid && out_ready && !last |=> out_valid && last && event_kind != ps2mt_pkg::EV_MOVE, "button word missing after move")

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2 mouse packet tracker testbench
// feeds mouse and foreign bytes through the input channel, tracks header,
// delta and button state plus the clamped cursor in a scoreboard, and checks
// every output word in order across several screen sizes
// ----------------------------------------------------------------------------
module tb;

  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE      = 8;
  localparam int PHASE_BYTES = 215;

  typedef struct {
    ps2mt_pkg::event_kind_t kind;
    logic [11:0]            x;
    logic [11:0]            y;
    logic                   last_word;
  } cursor_word_t;

  class cursor_board;
    cursor_word_t      pending_words[$];
    int                errors;
    ps2mt_pkg::phase_t phase;
    logic [7:0]        hdr;
    logic [7:0]        xbyte;
    logic [11:0]       cx;
    logic [11:0]       cy;
    logic              left_down;
    logic [12:0]       width;
    logic [12:0]       height;

    function new();
      errors    = 0;
      phase     = ps2mt_pkg::PH_HEADER;
      hdr       = '0;
      xbyte     = '0;
      cx        = '0;
      cy        = '0;
      left_down = 1'b0;
      width     = ps2mt_pkg::WIDTH_RESET;
      height    = ps2mt_pkg::HEIGHT_RESET;
    endfunction

    function void set_size(logic idx, logic [12:0] value);
      if (idx == ps2mt_pkg::REG_WIDTH) begin
        width = value;
      end else begin
        height = value;
      end
    endfunction

    function int limit_of(logic [12:0] size);
      if (size == 0) return 0;
      if (size > 4096) return 4095;
      return int'(size) - 1;
    endfunction

    function logic [11:0] clip(int v, int hi);
      if (v < 0) return '0;
      if (v > hi) return 12'(hi);
      return 12'(v);
    endfunction

    function void take_byte(logic [7:0] b, logic m);
      int           dx;
      int           dy;
      logic         left;
      cursor_word_t w;
      if (!m) return;
      if (phase == ps2mt_pkg::PH_XDELTA) begin
        xbyte = b;
        phase = ps2mt_pkg::PH_YDELTA;
        return;
      end
      if (phase != ps2mt_pkg::PH_YDELTA) begin
        hdr   = b;
        phase = b[ps2mt_pkg::HDR_SYNC_BIT] ? ps2mt_pkg::PH_XDELTA : ps2mt_pkg::PH_HEADER;
        return;
      end
      phase = ps2mt_pkg::PH_HEADER;
      dx = int'(xbyte) - (hdr[ps2mt_pkg::HDR_XSIGN_BIT] ? 256 : 0);
      dy = int'(b) - (hdr[ps2mt_pkg::HDR_YSIGN_BIT] ? 256 : 0);
      cx = clip(int'(cx) + dx, limit_of(width));
      cy = clip(int'(cy) - dy, limit_of(height));
      left = hdr[ps2mt_pkg::HDR_LEFT_BIT];
      w.kind      = ps2mt_pkg::EV_MOVE;
      w.x         = cx;
      w.y         = cy;
      w.last_word = (left == left_down);
      pending_words.push_back(w);
      if (left != left_down) begin
        if (left) begin
          w.kind = ps2mt_pkg::EV_DOWN;
        end else begin
          w.kind = ps2mt_pkg::EV_UP;
        end
        w.last_word = 1'b1;
        pending_words.push_back(w);
        left_down = left;
      end
    endfunction

    function void check_word(logic [1:0] kind, logic [11:0] x, logic [11:0] y, logic lst);
      cursor_word_t w;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word kind %0d x %0d y %0d last %0d",
                 $time, kind, x, y, lst);
        return;
      end
      w = pending_words.pop_front();
      if (kind !== w.kind || x !== w.x || y !== w.y || lst !== w.last_word) begin
        errors++;
        $display("%0t: expected kind %0d x %0d y %0d last %0d, %s",
                 $time, w.kind, w.x, w.y, w.last_word,
                 $sformatf("actual kind %0d x %0d y %0d last %0d", kind, x, y, lst));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        from_mouse;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  event_kind;
  logic [11:0] cursor_x_out;
  logic [11:0] cursor_y_out;
  logic        last;

  cursor_board board = new();
  int          tx_pct;
  int          rx_pct;
  int          mouse_bytes;

  ps2_mouse_packet_tracker u_top (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .from_mouse(from_mouse),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_kind(event_kind),
    .cursor_x_out(cursor_x_out),
    .cursor_y_out(cursor_y_out),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b, input logic m);
    if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    from_mouse <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_byte(b, m);
    if (m) mouse_bytes++;
  endtask

  task automatic send_mixed();
    int         pick;
    logic [7:0] head;
    pick = $urandom_range(0, 99);
    head = 8'($urandom);
    head[ps2mt_pkg::HDR_SYNC_BIT] = 1'b1;
    if (pick < 75) begin
      send_byte(head, 1'b1);
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b1);
      send_byte(8'($urandom), 1'b1);
    end else if (pick < 85) begin
      send_byte(8'($urandom), 1'b0);
    end else if (pick < 95) begin
      send_byte(8'($urandom), 1'b1);
    end else begin
      // packet cut short
      send_byte(head, 1'b1);
      if (pick < 98) send_byte(8'($urandom), 1'b1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [12:0] value);
    logic [18:0] junk;
    junk = 19'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.set_size(idx, value);
  endtask

  // receiver side: check accepted words, then pick next ready
  initial begin : rx_side
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        board.check_word(event_kind, cursor_x_out, cursor_y_out, last);
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (rx_pct != 0 && $urandom_range(0, 99) < rx_pct) begin
        hold = $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int widths[8];
    int heights[8];
    int tx_mix[3];
    int rx_mix[3];
    int target;
    widths      = '{640, 1, 4096, 0, 5000, 3, 0, 1024};
    heights     = '{480, 1, 4096, 8191, 2, 4097, 0, 768};
    tx_mix      = '{0, 10, 40};
    rx_mix      = '{35, 5, 0};
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    data_byte   = '0;
    from_mouse  = 1'b0;
    tx_pct      = 20;
    rx_pct      = 20;
    mouse_bytes = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed bytes at the reset screen size
    send_byte(8'h08, 1'b0);
    send_byte(8'h07, 1'b1);
    send_byte(8'h08, 1'b1);
    send_byte(8'h7f, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h29, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'hc8, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h39, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hf8, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h18, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h7f, 1'b1);

    for (int i = 0; i < 8; i++) begin
      drain();
      if (i == 6) begin
        widths[i]  = $urandom_range(1, 4096);
        heights[i] = $urandom_range(1, 4096);
      end
      write_reg(ps2mt_pkg::REG_WIDTH, 13'(widths[i]));
      write_reg(ps2mt_pkg::REG_HEIGHT, 13'(heights[i]));
      tx_pct = (i == 7) ? 0 : tx_mix[i % 3];
      rx_pct = (i == 7) ? 0 : rx_mix[i % 3];
      target = mouse_bytes + PHASE_BYTES;
      while (mouse_bytes < target) send_mixed();
    end

    drain();
    if (board.errors == 0 && board.pending_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ ps2_mouse_packet_tracker.f @@
+incdir+hdl
hdl/ps2mt_pkg.sv
hdl/ps2mt_fifo.sv
hdl/ps2mt_front.sv
hdl/ps2mt_back.sv
hdl/ps2_mouse_packet_tracker.sv
hdl/ps2mt_checker.sv
tb/tb.sv
